// ===== design/b3sh_pkg.sv =====
`default_nettype none
package b3sh_pkg;

   localparam int STACK_ENTRIES = 54;
   localparam int STACK_AW      = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(STACK_ENTRIES + 1);
   localparam int BLOCK_BYTES   = 64;
   localparam int MAX_WORDS     = 64;

   typedef logic [31:0]       word_type;
   typedef logic [7:0][31:0]  cv_type;
   typedef logic [15:0][31:0] blk_type;
   typedef logic [3:0][31:0]  quad_type;

   localparam cv_type IV = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                            32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

   localparam logic [7:0] FLAG_START  = 8'h01;
   localparam logic [7:0] FLAG_END    = 8'h02;
   localparam logic [7:0] FLAG_PARENT = 8'h04;
   localparam logic [7:0] FLAG_ROOT   = 8'h08;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_KEYED = 2'd1,
      MODE_DKC   = 2'd2,
      MODE_DKM   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_KEY0   = 3'd1,
      REG_KEY1   = 3'd2,
      REG_KEY2   = 3'd3,
      REG_KEY3   = 3'd4,
      REG_OWORDS = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      OP_BLOCK  = 2'd0,
      OP_CHUNK  = 2'd1,
      OP_PARENT = 2'd2,
      OP_ROOT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RD_TOP  = 2'd0,
      RD_IDX  = 2'd1,
      RD_BASE = 2'd2
   } rdsel_type;

   typedef struct packed {
      logic      load_item;
      logic      take_bytes;
      logic      core_start;
      op_type    op;
      logic      block_done;
      logic      node_load;
      logic      fold_init;
      logic      fold_pop;
      logic      push;
      logic      fin_init;
      logic      fin_dec;
      rdsel_type rd_sel;
      logic      root_chunk;
      logic      root_stack;
      logic      word_emit;
      logic      restart;
   } cmd_type;

   typedef struct packed {
      logic item_left;
      logic buf_full;
      logic chunk_full;
      logic core_done;
      logic fold_more;
      logic stack_empty;
      logic idx_more;
      logic word_last;
      logic block_end;
      logic out_free;
   } status_type;

   function automatic logic [63:0] perm_row(input logic [2:0] r);
      logic [63:0] row;
      case (r)
         3'd0:    row = 64'hFEDCBA9876543210;
         3'd1:    row = 64'h8FE95CB1D407A362;
         3'd2:    row = 64'h18FB0956E72DCA43;
         3'd3:    row = 64'h61852B04FD3E9C7A;
         3'd4:    row = 64'h461035278EAFB9DC;
         3'd5:    row = 64'h7462A03D1FC85BE9;
         3'd6:    row = 64'hD743C2AE689105FB;
         default: row = 64'hFEDCBA9876543210;
      endcase
      return row;
   endfunction

   function automatic logic [3:0] perm_idx(input logic [2:0] r, input logic [3:0] j);
      logic [63:0] row;
      row = perm_row(r);
      return row[{j, 2'b00} +: 4];
   endfunction

   function automatic word_type ror(input word_type w, input int n);
      return (w >> n) | (w << (32 - n));
   endfunction

   // one half of the mixing function: sec selects the second half's rotations (8 and 7 instead of 16 and 12)
   function automatic quad_type g_half(input word_type a, input word_type b,
                                       input word_type c, input word_type d,
                                       input word_type x, input logic sec);
      word_type a2, b2, c2, d2;
      a2 = a + b + x;
      d2 = sec ? ror(d ^ a2, 8) : ror(d ^ a2, 16);
      c2 = c + d2;
      b2 = sec ? ror(b ^ c2, 7) : ror(b ^ c2, 12);
      return {d2, c2, b2, a2};
   endfunction

endpackage
`default_nettype wire

// ===== design/b3sh_ram.sv =====
`default_nettype none
module b3sh_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 54
) (
   input  wire logic                                            clock,
   input  wire logic                                            we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
   input  wire logic [WIDTH-1:0]                                wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
   output logic      [WIDTH-1:0]                                rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== design/b3sh_core.sv =====
`default_nettype none
module b3sh_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire b3sh_pkg::cv_type  cv_in,
   input  wire b3sh_pkg::blk_type msg_in,
   input  wire logic [63:0]      ctr_in,
   input  wire logic [31:0]      len_in,
   input  wire logic [31:0]      flags_in,
   output logic                  done,
   output b3sh_pkg::blk_type     res
);
   import b3sh_pkg::*;

   localparam logic [4:0] LAST_STEP = 5'd27;

   blk_type    v_ff, v_in, m_ff;
   cv_type     cv_ff;
   logic [4:0] step_ff;
   logic       busy_ff, done_ff;

   // step: bit 0 half of G, bit 1 column or diagonal, bits 4:2 round
   always_comb begin
      quad_type   q;
      logic [1:0] gi;
      logic [3:0] j;
      v_in = v_ff;
      for (int g = 0; g < 4; g++) begin
         gi = 2'(g);
         j  = {step_ff[1], gi, step_ff[0]};
         if (!step_ff[1]) begin
            q = g_half(v_ff[g], v_ff[4+g], v_ff[8+g], v_ff[12+g],
                       m_ff[perm_idx(step_ff[4:2], j)], step_ff[0]);
            v_in[g]    = q[0];
            v_in[4+g]  = q[1];
            v_in[8+g]  = q[2];
            v_in[12+g] = q[3];
         end else begin
            q = g_half(v_ff[g], v_ff[4+((g+1)&3)], v_ff[8+((g+2)&3)],
                       v_ff[12+((g+3)&3)], m_ff[perm_idx(step_ff[4:2], j)], step_ff[0]);
            v_in[g]             = q[0];
            v_in[4+((g+1)&3)]   = q[1];
            v_in[8+((g+2)&3)]   = q[2];
            v_in[12+((g+3)&3)]  = q[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff  <= {flags_in, len_in, ctr_in[63:32], ctr_in[31:0], IV[3:0], cv_in};
         m_ff  <= msg_in;
         cv_ff <= cv_in;
      end else if (busy_ff) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         res[i]   = v_ff[i] ^ v_ff[i+8];
         res[i+8] = v_ff[i+8] ^ cv_ff[i];
      end
   end

   assign done = done_ff;
endmodule
`default_nettype wire

// ===== design/b3sh_datapath.sv =====
`default_nettype none
module b3sh_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [2:0]            csr_index,
   input  wire logic [63:0]           csr_data,
   input  wire logic [63:0]           req_data_bytes,
   input  wire logic [3:0]            req_byte_count,
   input  wire b3sh_pkg::cmd_type     cmd,
   output b3sh_pkg::status_type       status,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [63:0]                rsp_digest_word,
   output logic                       rsp_last
);
   import b3sh_pkg::*;

   logic [1:0]            mode_ff;
   logic [63:0]           key0_ff, key1_ff, key2_ff, key3_ff;
   logic [6:0]            owords_ff;
   logic [63:0][7:0]      buf_ff, buf_in;
   logic [6:0]            buffered_ff;
   logic [3:0]            blocks_ff;
   logic [63:0]           ctr_ff, total_ff, data_ff;
   cv_type                cv_ff, node_ff;
   logic [CNT_W-1:0]      count_ff, idx_ff;
   logic [3:0]            left_ff;
   logic [7:0]            root_flags_ff;
   logic [6:0]            k_ff;
   logic                  rsp_valid_ff, rsp_last_ff;
   logic [63:0]           rsp_word_ff;

   logic                  csr_hit, restart;
   cv_type                key_w, cv_eff;
   logic [7:0]            mflags, start_flag;
   logic [63:0][7:0]      mbuf;
   logic [6:0]            room, nwords;
   logic [3:0]            take_n;
   logic [5:0]            d;
   cv_type                core_cv;
   blk_type               core_msg, core_res;
   logic [63:0]           core_ctr;
   logic [31:0]           core_len, core_flags;
   logic                  core_done;
   logic [STACK_AW-1:0]   rd_addr, wr_addr;
   logic [255:0]          rd_data;
   logic [2:0]            wsel;

   assign csr_hit = csr_valid && (csr_index <= REG_OWORDS);
   assign restart = cmd.restart || csr_hit;

   always_comb begin
      case (mode_ff)
         MODE_KEYED: mflags = 8'h10;
         MODE_DKC:   mflags = 8'h20;
         MODE_DKM:   mflags = 8'h40;
         default:    mflags = 8'h00;
      endcase
      if (mode_ff == MODE_KEYED || mode_ff == MODE_DKM) begin
         key_w = {key3_ff, key2_ff, key1_ff, key0_ff};
      end else begin
         key_w = IV;
      end
   end

   // a fresh chunk chains from the key words (the IV in plain and DKC modes)
   assign cv_eff     = (blocks_ff == 4'd0) ? key_w : cv_ff;
   assign start_flag = (blocks_ff == 4'd0) ? FLAG_START : 8'h00;

   always_comb begin
      for (int p = 0; p < BLOCK_BYTES; p++) begin
         mbuf[p] = (7'(p) < buffered_ff) ? buf_ff[p] : 8'h00;
      end
   end

   always_comb begin
      room   = 7'(BLOCK_BYTES) - buffered_ff;
      take_n = ({3'b000, left_ff} < room) ? left_ff : room[3:0];
      for (int p = 0; p < BLOCK_BYTES; p++) begin
         d = 6'(p) - buffered_ff[5:0];
         if ((7'(p) >= buffered_ff) && (d < {2'b00, take_n})) begin
            buf_in[p] = data_ff[{d[2:0], 3'b000} +: 8];
         end else begin
            buf_in[p] = buf_ff[p];
         end
      end
   end

   always_comb begin
      core_cv    = cv_eff;
      core_msg   = mbuf;
      core_ctr   = ctr_ff;
      core_len   = {25'd0, buffered_ff};
      core_flags = {24'd0, mflags | start_flag};
      case (cmd.op)
         OP_BLOCK: ;
         OP_CHUNK: core_flags = {24'd0, mflags | start_flag | FLAG_END};
         OP_PARENT: begin
            core_cv    = key_w;
            core_msg   = {node_ff, rd_data};
            core_ctr   = 64'd0;
            core_len   = 32'(BLOCK_BYTES);
            core_flags = {24'd0, mflags | FLAG_PARENT};
         end
         OP_ROOT: begin
            core_ctr   = {60'd0, k_ff[6:3]};
            core_flags = {24'd0, root_flags_ff | FLAG_ROOT};
         end
         default: ;
      endcase
   end

   b3sh_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.core_start),
      .cv_in    (core_cv),
      .msg_in   (core_msg),
      .ctr_in   (core_ctr),
      .len_in   (core_len),
      .flags_in (core_flags),
      .done     (core_done),
      .res      (core_res)
   );

   always_comb begin
      case (cmd.rd_sel)
         RD_TOP:  rd_addr = STACK_AW'(count_ff - CNT_W'(1));
         RD_IDX:  rd_addr = STACK_AW'(idx_ff - CNT_W'(1));
         RD_BASE: rd_addr = '0;
         default: rd_addr = '0;
      endcase
      // a full stack overwrites its top entry
      wr_addr = (count_ff < CNT_W'(STACK_ENTRIES)) ? STACK_AW'(count_ff)
                                                   : STACK_AW'(STACK_ENTRIES - 1);
   end

   b3sh_ram #(
      .WIDTH (256),
      .DEPTH (STACK_ENTRIES)
   ) u_stack (
      .clock (clock),
      .we    (cmd.push),
      .waddr (wr_addr),
      .wdata (node_ff),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   always_comb begin
      if (owords_ff == 7'd0) begin
         nwords = 7'd1;
      end else if (owords_ff > 7'(MAX_WORDS)) begin
         nwords = 7'(MAX_WORDS);
      end else begin
         nwords = owords_ff;
      end
   end

   assign wsel = k_ff[2:0];

   always_comb begin
      status.item_left   = (left_ff != 4'd0);
      status.buf_full    = (buffered_ff == 7'(BLOCK_BYTES));
      status.chunk_full  = (blocks_ff == 4'd15);
      status.core_done   = core_done;
      status.fold_more   = !total_ff[0] && (count_ff != '0);
      status.stack_empty = (count_ff == '0);
      status.idx_more    = (idx_ff > CNT_W'(1));
      status.word_last   = ((k_ff + 7'd1) == nwords);
      status.block_end   = (wsel == 3'd7);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         key0_ff   <= '0;
         key1_ff   <= '0;
         key2_ff   <= '0;
         key3_ff   <= '0;
         owords_ff <= 7'd4;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE:   mode_ff   <= csr_data[1:0];
            REG_KEY0:   key0_ff   <= csr_data;
            REG_KEY1:   key1_ff   <= csr_data;
            REG_KEY2:   key2_ff   <= csr_data;
            REG_KEY3:   key3_ff   <= csr_data;
            REG_OWORDS: owords_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // hashing state
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         buffered_ff <= '0;
         blocks_ff   <= '0;
         ctr_ff      <= '0;
         count_ff    <= '0;
         k_ff        <= '0;
         left_ff     <= '0;
      end else begin
         if (cmd.load_item) begin
            left_ff <= (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
         end
         if (cmd.take_bytes) begin
            left_ff     <= left_ff - take_n;
            buffered_ff <= buffered_ff + {3'b000, take_n};
         end
         if (cmd.block_done) begin
            blocks_ff   <= blocks_ff + 4'd1;
            buffered_ff <= '0;
         end
         if (cmd.fold_pop) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.push) begin
            if (count_ff < CNT_W'(STACK_ENTRIES)) begin
               count_ff <= count_ff + CNT_W'(1);
            end
            ctr_ff      <= ctr_ff + 64'd1;
            blocks_ff   <= '0;
            buffered_ff <= '0;
         end
         if (cmd.root_stack) begin
            blocks_ff   <= '0;
            buffered_ff <= 7'(BLOCK_BYTES);
         end
         if (cmd.word_emit) begin
            k_ff <= k_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         data_ff <= req_data_bytes;
      end
      if (cmd.take_bytes) begin
         buf_ff  <= buf_in;
         data_ff <= data_ff >> {take_n, 3'b000};
      end
      if (cmd.root_stack) begin
         buf_ff <= {node_ff, rd_data};
      end
      if (cmd.block_done) begin
         cv_ff <= core_res[7:0];
      end
      if (cmd.node_load) begin
         node_ff <= core_res[7:0];
      end
      if (cmd.fold_init) begin
         total_ff <= ctr_ff + 64'd1;
      end else if (cmd.fold_pop) begin
         total_ff <= total_ff >> 1;
      end
      if (cmd.fin_init) begin
         idx_ff <= count_ff;
      end else if (cmd.fin_dec) begin
         idx_ff <= idx_ff - CNT_W'(1);
      end
      if (cmd.root_chunk) begin
         root_flags_ff <= mflags | start_flag | FLAG_END;
      end else if (cmd.root_stack) begin
         root_flags_ff <= mflags | FLAG_PARENT;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.word_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.word_emit) begin
         rsp_word_ff <= {core_res[{wsel, 1'b1}], core_res[{wsel, 1'b0}]};
         rsp_last_ff <= status.word_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_last        = rsp_last_ff;
endmodule
`default_nettype wire

// ===== design/b3sh_ctrl.sv =====
`default_nettype none
module b3sh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_ready,
   input  wire b3sh_pkg::status_type status,
   output b3sh_pkg::cmd_type         cmd
);
   import b3sh_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_BYTES    = 15'b000000000000010,
      S_BLK_WAIT = 15'b000000000000100,
      S_CHK_WAIT = 15'b000000000001000,
      S_FOLD     = 15'b000000000010000,
      S_FOLD_GO  = 15'b000000000100000,
      S_FOLD_WAIT= 15'b000000001000000,
      S_FIN_CHK  = 15'b000000010000000,
      S_FIN      = 15'b000000100000000,
      S_FIN_GO   = 15'b000001000000000,
      S_FIN_WAIT = 15'b000010000000000,
      S_ROOT_SET = 15'b000100000000000,
      S_OUT_CMP  = 15'b001000000000000,
      S_OUT_WAIT = 15'b010000000000000,
      S_EMIT     = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.op   = OP_BLOCK;
      cmd.rd_sel = RD_TOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  cmd.load_item = 1'b1;
                  state_in      = S_BYTES;
               end else if (status.stack_empty) begin
                  cmd.root_chunk = 1'b1;
                  state_in       = S_OUT_CMP;
               end else begin
                  cmd.core_start = 1'b1;
                  cmd.op         = OP_CHUNK;
                  state_in       = S_FIN_CHK;
               end
            end
         end
         S_BYTES: begin
            if (!status.item_left) begin
               state_in = S_IDLE;
            end else if (status.buf_full) begin
               cmd.core_start = 1'b1;
               if (status.chunk_full) begin
                  cmd.op   = OP_CHUNK;
                  state_in = S_CHK_WAIT;
               end else begin
                  cmd.op   = OP_BLOCK;
                  state_in = S_BLK_WAIT;
               end
            end else begin
               cmd.take_bytes = 1'b1;
            end
         end
         S_BLK_WAIT: begin
            if (status.core_done) begin
               cmd.block_done = 1'b1;
               state_in       = S_BYTES;
            end
         end
         S_CHK_WAIT: begin
            if (status.core_done) begin
               cmd.node_load = 1'b1;
               cmd.fold_init = 1'b1;
               state_in      = S_FOLD;
            end
         end
         S_FOLD: begin
            if (status.fold_more) begin
               cmd.rd_sel = RD_TOP;
               state_in   = S_FOLD_GO;
            end else begin
               cmd.push = 1'b1;
               state_in = S_BYTES;
            end
         end
         S_FOLD_GO: begin
            cmd.rd_sel     = RD_TOP;
            cmd.core_start = 1'b1;
            cmd.op         = OP_PARENT;
            state_in       = S_FOLD_WAIT;
         end
         S_FOLD_WAIT: begin
            if (status.core_done) begin
               cmd.node_load = 1'b1;
               cmd.fold_pop  = 1'b1;
               state_in      = S_FOLD;
            end
         end
         S_FIN_CHK: begin
            if (status.core_done) begin
               cmd.node_load = 1'b1;
               cmd.fin_init  = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (status.idx_more) begin
               cmd.rd_sel  = RD_IDX;
               cmd.fin_dec = 1'b1;
               state_in    = S_FIN_GO;
            end else begin
               cmd.rd_sel = RD_BASE;
               state_in   = S_ROOT_SET;
            end
         end
         S_FIN_GO: begin
            cmd.core_start = 1'b1;
            cmd.op         = OP_PARENT;
            state_in       = S_FIN_WAIT;
         end
         S_FIN_WAIT: begin
            if (status.core_done) begin
               cmd.node_load = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_ROOT_SET: begin
            cmd.root_stack = 1'b1;
            state_in       = S_OUT_CMP;
         end
         S_OUT_CMP: begin
            cmd.core_start = 1'b1;
            cmd.op         = OP_ROOT;
            state_in       = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            cmd.op = OP_ROOT;
            if (status.core_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.op = OP_ROOT;
            if (status.out_free) begin
               cmd.word_emit = 1'b1;
               if (status.word_last) begin
                  cmd.restart = 1'b1;
                  state_in    = S_IDLE;
               end else if (status.block_end) begin
                  state_in = S_OUT_CMP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/blake3_stream_hasher.sv =====
// Streaming BLAKE3 hasher with extended output.
// Input channel (req_): each beat is either up to eight message bytes
// (req_kind 0, first byte in the low bits, req_byte_count of them) or a
// finish beat (req_kind 1). One beat is taken at a time: a data beat is
// accepted, written into the block buffer, and then the hasher returns to
// idle, with a compression when the beat spills past a full block, and a
// chunk fold adds its parent merges on the chaining-value stack.
// The compression unit runs four mixing halves side by side per cycle.
// Result channel (rsp_): on finish the root is built (one parent merge per
// stack level beyond the first) and output_words 64-bit words follow (one
// if it is zero, at most 64), eight per root compression, the last flagged
// by rsp_last. A stalled receiver holds the output register and the block
// waits; input is refused until the digest is done.
// Configuration (csr_): register writes, always ready, restart the message;
// write only while nothing is in flight.
// Reset clears the message state and loads the default registers.
`default_nettype none
module blake3_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_data_bytes,
   input  wire logic [3:0]  req_byte_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import b3sh_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   b3sh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   b3sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_data_bytes  (req_data_bytes),
      .req_byte_count  (req_byte_count),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last        (rsp_last)
   );
endmodule
`default_nettype wire
